// ----- sv/fpga_slave_serial_config_loader_unit_assert.svh -----
// assertion macros for the slave-serial configuration loader
// no dependencies; define SYNTH to compile the checks away
`ifndef FPGA_SLAVE_SERIAL_CONFIG_LOADER_UNIT_ASSERT_SVH
`define FPGA_SLAVE_SERIAL_CONFIG_LOADER_UNIT_ASSERT_SVH
`ifndef SYNTH
// check under reset, disabled while rst_n is low
`define FSL_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("fsl assertion failed");
// check that also holds during reset
`define FSL_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("fsl assertion failed");
`else
`define FSL_ASSERT(lbl, clk, rstn, prop)
`define FSL_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- sv/fsl_pkg.sv -----
// shared types, codes and constants of the slave-serial configuration loader
// no dependencies
package fsl_pkg;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [15:0] INIT_TIMEOUT_RST = 16'h2000;

  typedef enum logic [1:0] {
    FN_BEGIN  = 2'd0,
    FN_POLL   = 2'd1,
    FN_DATA   = 2'd2,
    FN_FINISH = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_LOAD = 2'd2
  } phase_t;

  // one classified item, handed from front to back
  typedef struct packed {
    func_t       kind;
    logic [7:0]  data_byte;
    logic [3:0]  flags;
    logic        waiting;
  } cmd_t;

  // index of the final beat an item expands to
  function automatic logic [2:0] beat_max(input func_t kind);
    logic [2:0] m;
    case (kind)
      FN_BEGIN: m = 3'd1;
      FN_DATA:  m = 3'd7;
      default:  m = 3'd0;
    endcase
    return m;
  endfunction

endpackage

// ----- sv/fsl_in_if.sv -----
// input item channel of the configuration loader
// depends on nothing
interface fsl_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       init_level;
  logic       done_level;

  modport source (output valid, func, data_byte, last_byte, init_level, done_level,
                  input ready);
  modport sink   (input valid, func, data_byte, last_byte, init_level, done_level,
                  output ready);
endinterface

// ----- sv/fsl_out_if.sv -----
// result beat channel of the configuration loader
// depends on nothing
interface fsl_out_if;
  logic       valid;
  logic       ready;
  logic       din;
  logic       cclk_pulse;
  logic       prog_level;
  logic [3:0] error_flags;
  logic       waiting_init;
  logic       last;

  modport source (output valid, din, cclk_pulse, prog_level, error_flags, waiting_init,
                  last, input ready);
  modport sink   (input valid, din, cclk_pulse, prog_level, error_flags, waiting_init,
                  last, output ready);
endinterface

// ----- sv/fsl_front.sv -----
// front end: accepts items, tracks phase, countdown and error flags
// depends on fsl_pkg and fsl_in_if
module fsl_front import fsl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  fsl_in_if.sink      in_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_cmd
);

  phase_t      phase_r, phase_nxt;
  logic [15:0] cd_r, cd_nxt;
  logic [3:0]  err_r, err_nxt;
  logic [15:0] timeout_r;
  logic        acc;
  func_t       fn;

  assign in_ch.ready = !q_full;
  assign acc = in_ch.valid && in_ch.ready;
  assign fn  = func_t'(in_ch.func);

  // timeout register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= INIT_TIMEOUT_RST;
    end else if (cfg_we) begin
      timeout_r <= cfg_wdata;
    end
  end

  // phase next state
  always_comb begin
    phase_nxt = phase_r;
    if (acc) begin
      case (fn)
        FN_BEGIN: phase_nxt = PH_WAIT;
        FN_POLL: begin
          if (phase_r == PH_WAIT && (in_ch.init_level || cd_r <= 16'd1)) begin
            phase_nxt = PH_LOAD;
          end
        end
        FN_DATA: begin
          if (phase_r == PH_WAIT) begin
            phase_nxt = PH_LOAD;
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  // countdown, flags and the classified item
  always_comb begin
    cd_nxt  = cd_r;
    err_nxt = err_r;
    if (acc) begin
      case (fn)
        FN_BEGIN: begin
          err_nxt = 4'd0;
          cd_nxt  = timeout_r;
        end
        FN_POLL: begin
          if (phase_r == PH_WAIT && !in_ch.init_level) begin
            if (cd_r <= 16'd1) begin
              cd_nxt     = 16'd0;
              err_nxt[0] = 1'b1;
            end else begin
              cd_nxt = cd_r - 16'd1;
            end
          end
        end
        FN_DATA: begin
          if (!in_ch.last_byte) begin
            if (!in_ch.init_level) err_nxt[1] = 1'b1;
            if (in_ch.done_level)  err_nxt[2] = 1'b1;
          end
        end
        default: begin
          if (!in_ch.done_level) err_nxt[3] = 1'b1;
        end
      endcase
    end
    q_push          = acc;
    q_cmd.kind      = fn;
    q_cmd.data_byte = in_ch.data_byte;
    q_cmd.flags     = err_nxt;
    q_cmd.waiting   = (phase_nxt == PH_WAIT);
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cd_r    <= 16'd0;
      err_r   <= 4'd0;
    end else begin
      phase_r <= phase_nxt;
      cd_r    <= cd_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

// ----- sv/fsl_cmd_fifo.sv -----
// short queue of classified items between front and back
// depends on fsl_pkg
module fsl_cmd_fifo import fsl_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output cmd_t q_cmd
);

  cmd_t             mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(FIFO_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_cmd   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  // occupancy
  always_comb begin
    count_nxt = count_r;
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- sv/fsl_back.sv -----
// back end: expands each item into result beats behind an output register
// depends on fsl_pkg, fsl_out_if and the assertion header
`include "fpga_slave_serial_config_loader_unit_assert.svh"
module fsl_back import fsl_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   q_valid,
  input  cmd_t   q_cmd,
  output logic   q_pop,
  fsl_out_if.source out_ch
);

  cmd_t       cur_r;
  logic       cur_valid_r, cur_valid_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       din_r, cclk_r, prog_r, wait_r, last_r;
  logic [3:0] flags_r;
  logic       adv, beat_last;

  assign adv       = cur_valid_r && (!out_valid_r || out_ch.ready);
  assign beat_last = (cnt_r == beat_max(cur_r.kind));
  assign q_pop     = q_valid && (!cur_valid_r || (adv && beat_last));

  // beat sequencing
  always_comb begin
    cur_valid_nxt = cur_valid_r;
    cnt_nxt       = cnt_r;
    if (q_pop) begin
      cur_valid_nxt = 1'b1;
      cnt_nxt       = 3'd0;
    end else if (adv) begin
      cur_valid_nxt = !beat_last;
      cnt_nxt       = cnt_r + 3'd1;
    end
    out_valid_nxt = adv ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      cnt_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // current item and output beat
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_cmd;
    end
    if (adv) begin
      din_r   <= (cur_r.kind == FN_DATA) ? cur_r.data_byte[cnt_r] : 1'b0;
      cclk_r  <= (cur_r.kind == FN_DATA);
      prog_r  <= !((cur_r.kind == FN_BEGIN) && (cnt_r == 3'd0));
      flags_r <= cur_r.flags;
      wait_r  <= cur_r.waiting;
      last_r  <= beat_last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.din          = din_r;
  assign out_ch.cclk_pulse   = cclk_r;
  assign out_ch.prog_level   = prog_r;
  assign out_ch.error_flags  = flags_r;
  assign out_ch.waiting_init = wait_r;
  assign out_ch.last         = last_r;

  // checks
  `FSL_ASSERT(a_cnt_in_range, clk, rst_n, cur_valid_r |-> (cnt_r <= beat_max(cur_r.kind)))
  `FSL_ASSERT(a_adv_fills_out, clk, rst_n, adv |=> out_valid_r)
  `FSL_ASSERT(a_item_retires, clk, rst_n, (adv && beat_last && !q_pop) |=> !cur_valid_r)
  `FSL_ASSERT(a_no_pop_busy, clk, rst_n, (cur_valid_r && !(adv && beat_last)) |-> !q_pop)

endmodule

// ----- sv/fpga_slave_serial_config_loader_unit.sv -----
// slave-serial configuration loader: front classifier, item queue, beat generator
// the first result beat passes through the item queue, the current-item register and the output register
// throughput: one result beat per cycle from the beat generator while the output is not stalled; a data
//   byte expands to 8 beats, a begin item to 2, poll and finish items to 1
// reset (rst_n low, synchronous): phase idle, countdown and flags zero, timeout 8192,
//   queue and output empty
module fpga_slave_serial_config_loader_unit import fsl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  fsl_in_if.sink      in_ch,
  fsl_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic q_full, q_push, q_pop, q_valid;
  cmd_t push_cmd, q_cmd;

  // item classification and state tracking
  fsl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  // decoupling queue
  fsl_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  // beat expansion
  fsl_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
